### design/ele_pkg.sv
// Shared types and constants of the epipolar line error block.
`default_nettype none
package ele_pkg;

    localparam int ENT_W   = 20;   // Q2.17 essential matrix entry
    localparam int ROW_W   = 3 * ENT_W;
    localparam int PT_W    = 24;   // Q4.19 coordinate
    localparam int SCALE_W = 20;   // Q12.8 focal over sigma
    localparam int ERR_W   = 32;   // Q24.8 result
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    // Line unit pipeline depth in stages (eight arithmetic stages, 32 divide stages).
    localparam int LINE_LAT = 40;

    // Register indexes (byte address is 8 * index).
    localparam logic [2:0] REG_ROW0   = 3'd0;
    localparam logic [2:0] REG_ROW1   = 3'd1;
    localparam logic [2:0] REG_ROW2   = 3'd2;
    localparam logic [2:0] REG_SCALE1 = 3'd3;
    localparam logic [2:0] REG_SCALE2 = 3'd4;

    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(256);
    localparam logic [ERR_W-1:0]   ERR_SAT   = '1;

    typedef logic signed [ENT_W-1:0] ent_t;

    // Coefficients of one line: a, b, c each as a weighted sum of (x, y, 1).
    typedef struct packed {
        ent_t [2:0] ka;
        ent_t [2:0] kb;
        ent_t [2:0] kc;
    } line_coef_t;

endpackage
`default_nettype wire

### design/epipolar_line_error.sv
// Top level of the symmetric epipolar line error block.
// Takes one point correspondence per word on the s_ side and returns the
// larger of the two scaled squared point-to-epipolar-line distances on the
// m_ side, one result word per input word, in order. The essential matrix
// and the two focal/sigma scales are written through the APB port; the user
// must write them only while the block is idle; the block does not enforce
// it. One word is accepted every cycle while the pipeline advances; each word
// passes eight arithmetic stages, 32 one-bit-per-stage divider stages and one
// output register. The pipeline moves together: it advances whenever the
// output register is empty or its word is taken, so a stall on the m_ side
// holds every stage. A zero direction norm gives an all-ones error and sets
// the degenerate flag; errors of 2^32 or more in Q24.8 saturate to all ones.
`default_nettype none
module epipolar_line_error
    import ele_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input words
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [95:0]        s_tdata,   // first_x, first_y, second_x, second_y
    // result words
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,   // squared_error
    output logic                    m_tuser,   // degenerate
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    logic [ROW_W-1:0]   row0_reg, row1_reg, row2_reg;
    logic [SCALE_W-1:0] scale1_reg, scale2_reg;
    logic [2:0]         reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg   <= '0;
            row1_reg   <= '0;
            row2_reg   <= '0;
            scale1_reg <= SCALE_RST;
            scale2_reg <= SCALE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROW0:   row0_reg   <= pwdata[ROW_W-1:0];
                REG_ROW1:   row1_reg   <= pwdata[ROW_W-1:0];
                REG_ROW2:   row2_reg   <= pwdata[ROW_W-1:0];
                REG_SCALE1: scale1_reg <= pwdata[SCALE_W-1:0];
                REG_SCALE2: scale2_reg <= pwdata[SCALE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROW0:   prdata = DATA_W'(row0_reg);
            REG_ROW1:   prdata = DATA_W'(row1_reg);
            REG_ROW2:   prdata = DATA_W'(row2_reg);
            REG_SCALE1: prdata = DATA_W'(scale1_reg);
            REG_SCALE2: prdata = DATA_W'(scale2_reg);
            default:    prdata = '0;
        endcase
    end

    // matrix entries e[r][c]
    ent_t [2:0] r0, r1, r2;
    assign r0 = row0_reg;
    assign r1 = row1_reg;
    assign r2 = row2_reg;

    // line in second view is E*p1, line in first view is E^T*p2
    line_coef_t coef2, coef1;
    always_comb
    begin
        coef2.ka = r0;
        coef2.kb = r1;
        coef2.kc = r2;
        coef1.ka = {r2[0], r1[0], r0[0]};
        coef1.kb = {r2[1], r1[1], r0[1]};
        coef1.kc = {r2[2], r1[2], r0[2]};
    end

    logic signed [PT_W-1:0] x1, y1, x2, y2;
    assign x1 = s_tdata[23:0];
    assign y1 = s_tdata[47:24];
    assign x2 = s_tdata[71:48];
    assign y2 = s_tdata[95:72];

    // global pipeline advance
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [ERR_W-1:0] err1, err2;
    logic             deg1, deg2;

    ele_line u_line2 (
        .clk   (clk),
        .en    (en),
        .coef  (coef2),
        .src_x (x1),
        .src_y (y1),
        .dst_x (x2),
        .dst_y (y2),
        .scale (scale2_reg),
        .err   (err2),
        .deg   (deg2)
    );

    ele_line u_line1 (
        .clk   (clk),
        .en    (en),
        .coef  (coef1),
        .src_x (x2),
        .src_y (y2),
        .dst_x (x1),
        .dst_y (y1),
        .scale (scale1_reg),
        .err   (err1),
        .deg   (deg1)
    );

    // valid bits travel beside the line units
    logic [LINE_LAT-1:0] vld_reg;
    logic [31:0]         err_reg;
    logic                deg_reg;
    logic                out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[LINE_LAT-2:0], s_tvalid};
            out_vld_reg <= vld_reg[LINE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg <= (err1 > err2) ? err1 : err2;
            deg_reg <= deg1 || deg2;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = err_reg;
    assign m_tuser  = deg_reg;

    // a degenerate line always forces the saturated error
    a_deg_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == ERR_SAT))
        else $error("degenerate result without saturated error");

    // an accepted word enters the first valid stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted word lost at pipeline entry");

    // a stall freezes the valid chain
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

### design/ele_line.sv
// One epipolar line: build the line, score the point against it, divide.
`default_nettype none
module ele_line
    import ele_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire line_coef_t               coef,
    input  wire logic signed [PT_W-1:0]   src_x,
    input  wire logic signed [PT_W-1:0]   src_y,
    input  wire logic signed [PT_W-1:0]   dst_x,
    input  wire logic signed [PT_W-1:0]   dst_y,
    input  wire logic [SCALE_W-1:0]       scale,
    output logic [ERR_W-1:0]              err,
    output logic                          deg
);

    function automatic logic signed [45:0] lin3(input ent_t k0, input ent_t k1,
                                                input ent_t k2,
                                                input logic signed [PT_W-1:0] x,
                                                input logic signed [PT_W-1:0] y);
        logic signed [45:0] s;
        s = $signed(k0) * x + $signed(k1) * y + ($signed(k2) <<< 19);
        return s;
    endfunction

    // Round 36 to 24 fraction bits, ties away from zero; returns magnitude.
    function automatic logic [31:0] rnd_mag(input logic signed [45:0] v);
        logic [46:0] m;
        m = v[45] ? 47'(-v) : 47'(v);
        m = m + 47'd2048;
        return m[43:12];
    endfunction

    function automatic logic signed [32:0] to_signed(input logic neg,
                                                      input logic [31:0] m);
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // stage A: line coefficients, 36 fraction bits
    logic signed [45:0] a_reg, b_reg, c_reg;
    logic signed [PT_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    // stage B: rounded line
    logic [31:0] ua_reg, ub_reg;
    logic signed [32:0] la_reg, lb_reg, lc_reg;
    // stage C: products
    logic [63:0] sqa_reg, sqb_reg;
    logic signed [56:0] pa_reg, pb_reg;
    logic signed [32:0] lc2_reg;
    // stage D: norm and distance
    logic [63:0] nd_reg, ne_reg, nf_reg, ng_reg;
    logic dd_reg, de_reg, df_reg, dg_reg;
    logic [36:0] dsh_reg;
    // stage E..G: scaled distance and its square
    logic [56:0] q_reg;
    logic [55:0] hh_reg;
    logic [56:0] hl_reg;
    logic [57:0] ll_reg;
    logic [113:0] sq_reg;

    // divider pipeline, index 0 is the setup stage
    logic [63:0] rem_reg [0:32];
    logic [31:0] low_reg [0:32];
    logic [31:0] quo_reg [0:32];
    logic [63:0] n_reg   [0:32];
    logic        sat_reg [0:32];
    logic        dg_p_reg [0:32];

    logic signed [58:0] dot;
    logic [58:0]        dmag;
    logic [95:0]        vq;

    always_comb
    begin
        dot  = 59'(pa_reg) + 59'(pb_reg) + (59'(lc2_reg) <<< 19);
        dmag = dot[58] ? 59'(-dot) : 59'(dot);
        vq   = sq_reg[103:8];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= lin3(coef.ka[0], coef.ka[1], coef.ka[2], src_x, src_y);
            b_reg  <= lin3(coef.kb[0], coef.kb[1], coef.kb[2], src_x, src_y);
            c_reg  <= lin3(coef.kc[0], coef.kc[1], coef.kc[2], src_x, src_y);
            ax_reg <= dst_x;
            ay_reg <= dst_y;

            ua_reg <= rnd_mag(a_reg);
            ub_reg <= rnd_mag(b_reg);
            la_reg <= to_signed(a_reg[45], rnd_mag(a_reg));
            lb_reg <= to_signed(b_reg[45], rnd_mag(b_reg));
            lc_reg <= to_signed(c_reg[45], rnd_mag(c_reg));
            bx_reg <= ax_reg;
            by_reg <= ay_reg;

            sqa_reg <= 64'(ua_reg) * 64'(ua_reg);
            sqb_reg <= 64'(ub_reg) * 64'(ub_reg);
            pa_reg  <= 57'(bx_reg) * 57'(la_reg);
            pb_reg  <= 57'(by_reg) * 57'(lb_reg);
            lc2_reg <= lc_reg;

            nd_reg  <= sqa_reg + sqb_reg;
            dd_reg  <= (sqa_reg + sqb_reg) == 64'd0;
            dsh_reg <= dmag[55:19];

            q_reg  <= 57'(dsh_reg) * 57'(scale);
            ne_reg <= nd_reg;
            de_reg <= dd_reg;

            hh_reg <= 56'(q_reg[56:29]) * 56'(q_reg[56:29]);
            hl_reg <= 57'(q_reg[56:29]) * 57'(q_reg[28:0]);
            ll_reg <= 58'(q_reg[28:0]) * 58'(q_reg[28:0]);
            nf_reg <= ne_reg;
            df_reg <= de_reg;

            sq_reg <= (114'(hh_reg) << 58) + (114'(hl_reg) << 30) + 114'(ll_reg);
            ng_reg <= nf_reg;
            dg_reg <= df_reg;

            // quotient would reach 2^32: saturate
            rem_reg[0]  <= vq[95:32];
            low_reg[0]  <= vq[31:0];
            quo_reg[0]  <= '0;
            n_reg[0]    <= ng_reg;
            sat_reg[0]  <= (|sq_reg[113:104]) || (vq[95:32] >= ng_reg);
            dg_p_reg[0] <= dg_reg;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < 32; k++)
    begin : g_div
        logic [64:0] r2;
        logic        ge;
        assign r2 = {rem_reg[k], low_reg[k][31]};
        assign ge = r2 >= {1'b0, n_reg[k]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? 64'(r2 - {1'b0, n_reg[k]}) : r2[63:0];
                low_reg[k+1]  <= {low_reg[k][30:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][30:0], ge};
                n_reg[k+1]    <= n_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
                dg_p_reg[k+1] <= dg_p_reg[k];
            end
        end
    end

    assign err = (sat_reg[32] || dg_p_reg[32]) ? ERR_SAT : quo_reg[32];
    assign deg = dg_p_reg[32];

endmodule
`default_nettype wire

### sim/epipolar_line_error_checker.sv
// Result predictor and scoreboard for the epipolar line error block.
`timescale 1ns / 100ps
module epipolar_line_error_checker
    import ele_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [95:0]        s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [31:0]        m_tdata,
    input  wire logic               m_tuser,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output int                      fail_count,
    output int                      pending_count,
    output int                      result_count,
    output int                      degenerate_count,
    output int                      saturated_count
);

    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic             deg;
    } line_result_t;

    logic [ROW_W-1:0]   ess [3];
    logic [SCALE_W-1:0] scale_a, scale_b;
    line_result_t       expected_q [$];

    function automatic logic signed [127:0] entry(int r, int k);
        logic signed [ENT_W-1:0] e;
        e = ess[r][k*ENT_W +: ENT_W];
        return 128'(e);
    endfunction

    // magnitude rounding 36 -> 24 fraction bits, ties away from zero
    function automatic logic signed [127:0] round_coef(logic signed [127:0] v);
        logic [127:0] m;
        m = v < 0 ? -v : v;
        m = (m + 128'd2048) >> 12;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [ERR_W-1:0] line_distance(
        logic signed [127:0] a36, logic signed [127:0] b36, logic signed [127:0] c36,
        logic signed [127:0] x, logic signed [127:0] y, logic [SCALE_W-1:0] sc,
        inout logic deg);
        logic signed [127:0] la, lb, lc, dot;
        logic [127:0] n, d, q, sq;
        la = round_coef(a36);
        lb = round_coef(b36);
        lc = round_coef(c36);
        n = la * la + lb * lb;
        dot = x * la + y * lb + lc * 128'sd524288;
        d = dot < 0 ? -dot : dot;
        if (n == 0)
        begin
            deg = 1'b1;
            return ERR_SAT;
        end
        q = (d >> 19) * sc;
        sq = (q * q) >> 8;
        sq = sq / n;
        return (sq >> 32) != 0 ? ERR_SAT : sq[31:0];
    endfunction

    function automatic line_result_t predict_error(logic [95:0] w);
        logic signed [127:0] x1, y1, x2, y2, one;
        logic [ERR_W-1:0] e1, e2;
        logic deg;
        line_result_t res;
        x1 = 128'($signed(w[23:0]));
        y1 = 128'($signed(w[47:24]));
        x2 = 128'($signed(w[71:48]));
        y2 = 128'($signed(w[95:72]));
        one = 128'sd524288;
        deg = 1'b0;
        e2 = line_distance(entry(0,0)*x1 + entry(0,1)*y1 + entry(0,2)*one,
                           entry(1,0)*x1 + entry(1,1)*y1 + entry(1,2)*one,
                           entry(2,0)*x1 + entry(2,1)*y1 + entry(2,2)*one,
                           x2, y2, scale_b, deg);
        e1 = line_distance(entry(0,0)*x2 + entry(1,0)*y2 + entry(2,0)*one,
                           entry(0,1)*x2 + entry(1,1)*y2 + entry(2,1)*one,
                           entry(0,2)*x2 + entry(1,2)*y2 + entry(2,2)*one,
                           x1, y1, scale_a, deg);
        res.err = e1 > e2 ? e1 : e2;
        res.deg = deg;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t want;
        if (!rst_n)
        begin
            ess[0] <= '0;
            ess[1] <= '0;
            ess[2] <= '0;
            scale_a <= SCALE_RST;
            scale_b <= SCALE_RST;
            fail_count <= 0;
            pending_count <= 0;
            result_count <= 0;
            degenerate_count <= 0;
            saturated_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr[5:3])
                    REG_ROW0:   ess[0]  <= pwdata[ROW_W-1:0];
                    REG_ROW1:   ess[1]  <= pwdata[ROW_W-1:0];
                    REG_ROW2:   ess[2]  <= pwdata[ROW_W-1:0];
                    REG_SCALE1: scale_a <= pwdata[SCALE_W-1:0];
                    REG_SCALE2: scale_b <= pwdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_error(s_tdata));
            if (m_tvalid && m_tready)
            begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word err=%h deg=%b", m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.deg) degenerate_count <= degenerate_count + 1;
                    if (want.err == ERR_SAT) saturated_count <= saturated_count + 1;
                    if (want.err !== m_tdata || want.deg !== m_tuser)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: err exp %h got %h, deg exp %b got %b",
                                     want.err, m_tdata, want.deg, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_q.size();
        end
    end

endmodule

### sim/epipolar_line_error_test.sv
// Stimulus and verdict for the epipolar line error block.
`timescale 1ns / 100ps
module epipolar_line_error_test;
    import ele_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [95:0]        s_tdata = '0;      // first_x, first_y, second_x, second_y
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;           // squared_error
    logic               m_tuser;           // degenerate
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    int                 fail_count, pending_count, result_count;
    int                 degenerate_count, saturated_count;

    // idle odds in percent; hold_off forces a long receiver stall
    int                 send_idle = 0, recv_idle = 0;
    int                 hold_off = 0;
    int                 word_count = 0;

    always #5 clk = ~clk;

    epipolar_line_error i_dut (.*);

    epipolar_line_error_checker i_check (.*);

    // receiver: random stall, or a counted hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 3'b000}); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // wait until every result is back, then let the pipeline drain
    task automatic drain_results();
        while (pending_count != 0) @(posedge clk);
        repeat (LINE_LAT + 10) @(posedge clk);
    endtask

    task automatic send_word(logic [95:0] w);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        word_count++;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(2 * 524288)) - 524288);
            default: return 24'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    function automatic logic [19:0] rand_entry(int mode);
        case (mode)
            0: return 20'($urandom);
            1: return 20'($signed($urandom_range(2 * 131072)) - 131072);
            default: return 20'h0;
        endcase
    endfunction

    function automatic logic [59:0] rand_row(int mode);
        return {rand_entry($urandom_range(1) ? mode : 0),
                rand_entry(mode), rand_entry(mode)};
    endfunction

    // one phase: new matrix and scales, then a batch of random correspondences
    task automatic run_phase(logic [59:0] r0, logic [59:0] r1, logic [59:0] r2,
                             logic [19:0] s1, logic [19:0] s2, int count);
        int mode;
        write_reg(REG_ROW0, 64'(r0));
        write_reg(REG_ROW1, 64'(r1));
        write_reg(REG_ROW2, 64'(r2));
        write_reg(REG_SCALE1, 64'(s1));
        write_reg(REG_SCALE2, 64'(s2));
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(2);
            send_word({rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)});
        end
        idle_sender();
        drain_results();
    endtask

    initial
    begin
        logic [59:0] ident_like;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset matrix is zero: every line degenerate
        send_word({24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF});
        idle_sender();
        drain_results();

        // directed: a cross-product style matrix with extremes
        ident_like = {20'h00000, 20'h20000, 20'h00000};
        write_reg(REG_ROW0, 64'({20'h00000, 20'h00000, 20'h00000}));
        write_reg(REG_ROW1, 64'({20'h20000, 20'h00000, 20'h00000}));
        write_reg(REG_ROW2, 64'({20'h00000, 20'hE0000, 20'h00000}));
        write_reg(REG_SCALE1, 64'(20'hFFFFF));
        write_reg(REG_SCALE2, 64'(20'h00000));
        send_word({24'h000000, 24'h000000, 24'h000000, 24'h000000});
        send_word({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
        send_word({24'h800000, 24'h800000, 24'h800000, 24'h800000});
        send_word({24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000});
        send_word({24'h080000, 24'h000001, 24'hFFFFFF, 24'h080000});
        send_word({24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA});
        idle_sender();
        drain_results();
        write_reg(REG_ROW0, 64'({20'h7FFFF, 20'h80000, 20'h7FFFF}));
        write_reg(REG_ROW1, 64'({20'h80000, 20'h7FFFF, 20'h80000}));
        write_reg(REG_ROW2, 64'(ident_like));
        write_reg(REG_SCALE2, 64'(20'hFFFFF));
        send_word({24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF});
        send_word({24'h000001, 24'hFFFFFF, 24'h000000, 24'h000000});
        send_word({24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555});
        idle_sender();
        drain_results();

        // random phases: sender light / receiver heavy, swapped, then no idling
        send_idle = 21; recv_idle = 83;
        run_phase(rand_row(1), rand_row(1), rand_row(1), 20'd256, 20'd256, 300);
        run_phase(rand_row(0), rand_row(0), rand_row(0), 20'($urandom), 20'($urandom), 150);
        send_idle = 83; recv_idle = 21;
        run_phase(rand_row(1), rand_row(2), rand_row(1), 20'd1, 20'hFFFFF, 300);
        send_idle = 0; recv_idle = 0;
        // long receiver hold-off while the sender keeps offering words
        hold_off = 200;
        run_phase(rand_row(1), rand_row(1), rand_row(0), 20'($urandom), 20'($urandom), 300);
        run_phase(rand_row(0), rand_row(1), rand_row(1), 20'hFFFFF, 20'd0, 250);

        $display("%0d correspondences checked over several matrix and scale settings,",
                 word_count);
        $display("%0d results, %0d degenerate, %0d saturated",
                 result_count, degenerate_count, saturated_count);
        if (fail_count == 0)
            $display("[epipolar_line_error] OK");
        else
            $display("[epipolar_line_error] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[epipolar_line_error] ERROR");
        $finish;
    end

endmodule

### files.f
design/ele_pkg.sv
design/ele_line.sv
design/epipolar_line_error.sv
sim/epipolar_line_error_checker.sv
sim/epipolar_line_error_test.sv
